@@ hdl/cable_rod_contact_generator_defines.svh @@
// Assertion helpers shared by the checker.
`ifndef CABLE_ROD_CONTACT_GENERATOR_DEFINES_SVH
`define CABLE_ROD_CONTACT_GENERATOR_DEFINES_SVH

// Condition holds at every edge outside reset.
`define CRCG_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// Antecedent implies consequent at the next edge, outside reset.
`define CRCG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Antecedent implies consequent at the same edge, checked during reset too.
`define CRCG_ASSERT_SAME(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

@@ hdl/crcg_pkg.sv @@
`default_nettype none
package crcg_pkg;

  localparam int FRAC_BITS = 16;

  localparam int POS_W   = 32;
  localparam int DIFF_W  = 33;
  localparam int MAG_W   = 33;
  localparam int SQ_W    = 65;
  localparam int SUM_W   = 66;
  localparam int ROOT_W  = 33;
  localparam int REM_W   = 36;
  localparam int DREM_W  = 34;
  localparam int DEPTH_W = 33;
  localparam int REST_W  = 17;
  localparam int IDX_W   = 2;

  localparam logic [REST_W-1:0] REST_ONE   = 17'd65536;
  localparam logic [DEPTH_W-1:0] REST_INIT = 33'd65536;
  localparam logic LINK_ROD = 1'b1;

  typedef enum logic [IDX_W-1:0] {
    REG_LINK_KIND   = 2'd0,
    REG_REST_LENGTH = 2'd1,
    REG_RESTITUTION = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic                  valid;
    logic [2:0]            sign;
    logic [2:0][MAG_W-1:0] mag;
  } sq_ctl_t;

  typedef struct packed {
    logic               valid;
    logic               flip;
    logic [2:0]         sign;
    logic [ROOT_W-1:0]  span;
    logic [DEPTH_W-1:0] depth;
    logic [REST_W-1:0]  rest;
  } div_ctl_t;

endpackage
`default_nettype wire

@@ hdl/crcg_pos_if.sv @@
`default_nettype none
interface crcg_pos_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] first_x;
  logic signed [31:0] first_y;
  logic signed [31:0] first_z;
  logic signed [31:0] second_x;
  logic signed [31:0] second_y;
  logic signed [31:0] second_z;

  modport source (output valid, first_x, first_y, first_z, second_x, second_y, second_z,
                  input ready);
  modport sink (input valid, first_x, first_y, first_z, second_x, second_y, second_z,
                output ready);
endinterface
`default_nettype wire

@@ hdl/crcg_contact_if.sv @@
`default_nettype none
interface crcg_contact_if #(parameter int NORM_W = 18);
  logic                     valid;
  logic                     ready;
  logic signed [NORM_W-1:0] normal_x;
  logic signed [NORM_W-1:0] normal_y;
  logic signed [NORM_W-1:0] normal_z;
  logic [32:0]              depth;
  logic [16:0]              contact_restitution;

  modport source (output valid, normal_x, normal_y, normal_z, depth, contact_restitution,
                  input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, depth, contact_restitution,
                output ready);
endinterface
`default_nettype wire

@@ hdl/crcg_cfg_if.sv @@
`default_nettype none
interface crcg_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [32:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ hdl/crcg_sqrt_cell.sv @@
`default_nettype none
module crcg_sqrt_cell import crcg_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire sq_ctl_t           ctl_in,
  input  wire logic [SUM_W-1:0]  rad_in,
  input  wire logic [REM_W-1:0]  rem_in,
  input  wire logic [ROOT_W-1:0] root_in,
  output sq_ctl_t                ctl_out,
  output logic [SUM_W-1:0]       rad_out,
  output logic [REM_W-1:0]       rem_out,
  output logic [ROOT_W-1:0]      root_out
);

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             fits;

  // Bring down the next two radicand bits and try appending a one to the root.
  always_comb begin
    rem_sh = {rem_in[REM_W-3:0], rad_in[SUM_W-1:SUM_W-2]};
    trial  = {{(REM_W-ROOT_W-2){1'b0}}, root_in, 2'b01};
    fits   = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (en) begin
      ctl_out.valid <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_out.sign <= ctl_in.sign;
      ctl_out.mag  <= ctl_in.mag;
      rad_out      <= {rad_in[SUM_W-3:0], 2'b00};
      rem_out      <= fits ? rem_sh - trial : rem_sh;
      root_out     <= {root_in[ROOT_W-2:0], fits};
    end
  end

endmodule
`default_nettype wire

@@ hdl/crcg_div_cell.sv @@
`default_nettype none
module crcg_div_cell import crcg_pkg::*; #(
  parameter int Q_W   = 17,
  parameter bit FIRST = 1'b0
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   en,
  input  wire div_ctl_t               ctl_in,
  input  wire logic [2:0][DREM_W-1:0] rem_in,
  input  wire logic [2:0][Q_W-1:0]    q_in,
  output div_ctl_t                    ctl_out,
  output logic [2:0][DREM_W-1:0]      rem_out,
  output logic [2:0][Q_W-1:0]         q_out
);

  logic [2:0][DREM_W-1:0] t;
  logic [2:0][DREM_W-1:0] rem_next;
  logic [2:0]             fit;
  logic [DREM_W-1:0]      divisor;

  // One quotient bit per lane; the top bit compares the unshifted magnitude.
  always_comb begin
    divisor = {{(DREM_W-ROOT_W){1'b0}}, ctl_in.span};
    for (int i = 0; i < 3; i++) begin
      t[i]        = FIRST ? rem_in[i] : {rem_in[i][DREM_W-2:0], 1'b0};
      fit[i]      = t[i] >= divisor;
      rem_next[i] = fit[i] ? t[i] - divisor : t[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (en) begin
      ctl_out.valid <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_out.flip  <= ctl_in.flip;
      ctl_out.sign  <= ctl_in.sign;
      ctl_out.span  <= ctl_in.span;
      ctl_out.depth <= ctl_in.depth;
      ctl_out.rest  <= ctl_in.rest;
      rem_out       <= rem_next;
      for (int i = 0; i < 3; i++) begin
        q_out[i] <= {q_in[i][Q_W-2:0], fit[i]};
      end
    end
  end

endmodule
`default_nettype wire

@@ hdl/cable_rod_contact_generator.sv @@
// Throughput: one link per cycle; a stalled output freezes the whole pipeline.
// Most of the pipeline's stages are the 33-cell square-root chain and FRAC_BITS + 1 divider cells.
// Links that yield no contact leave a bubble and produce no output transfer.
// Reset (synchronous, rst high) clears all valid bits and loads the register
// defaults: cable mode, rest length one, restitution zero.
`default_nettype none
module cable_rod_contact_generator import crcg_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  crcg_pos_if.sink  pos,
  crcg_contact_if.source contact,
  crcg_cfg_if.sink  cfg
);

  localparam int Q_W    = FRAC_BITS + 1;
  localparam int NORM_W = FRAC_BITS + 2;

  logic               link_kind;
  logic [DEPTH_W-1:0] rest_length;
  logic [REST_W-1:0]  restitution_coef;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      link_kind        <= 1'b0;
      rest_length      <= REST_INIT;
      restitution_coef <= '0;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_LINK_KIND:   link_kind   <= cfg.data[0];
        REG_REST_LENGTH: rest_length <= cfg.data;
        REG_RESTITUTION: restitution_coef <=
          (cfg.data[REST_W-1:0] > REST_ONE) ? REST_ONE : cfg.data[REST_W-1:0];
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv       = !contact.valid || contact.ready;
  assign pos.ready = adv;

  // Front end: difference, magnitude, squares, sum.
  logic                          v0, v1, v2, v3;
  logic signed [2:0][DIFF_W-1:0] d0;
  logic [2:0][MAG_W-1:0]         m1, m2;
  logic [2:0]                    s1, s2;
  logic [2:0][SQ_W-1:0]          sq2;
  sq_ctl_t                       ctl3;
  logic [SUM_W-1:0]              sum3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v0 <= pos.valid;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d0[0] <= DIFF_W'(pos.second_x) - DIFF_W'(pos.first_x);
      d0[1] <= DIFF_W'(pos.second_y) - DIFF_W'(pos.first_y);
      d0[2] <= DIFF_W'(pos.second_z) - DIFF_W'(pos.first_z);
      for (int i = 0; i < 3; i++) begin
        s1[i]  <= d0[i][DIFF_W-1];
        m1[i]  <= d0[i][DIFF_W-1] ? MAG_W'(-d0[i]) : MAG_W'(d0[i]);
        s2[i]  <= s1[i];
        m2[i]  <= m1[i];
        sq2[i] <= SQ_W'({{(SQ_W-MAG_W){1'b0}}, m1[i]} * {{(SQ_W-MAG_W){1'b0}}, m1[i]});
      end
      ctl3.sign <= s2;
      ctl3.mag  <= m2;
      sum3      <= SUM_W'(sq2[0]) + SUM_W'(sq2[1]) + SUM_W'(sq2[2]);
    end
  end

  always_comb ctl3.valid = v3;

  // Square-root chain: one root bit per cell.
  sq_ctl_t           sctl  [0:ROOT_W];
  logic [SUM_W-1:0]  srad  [0:ROOT_W];
  logic [REM_W-1:0]  srem  [0:ROOT_W];
  logic [ROOT_W-1:0] sroot [0:ROOT_W];

  assign sctl[0]  = ctl3;
  assign srad[0]  = sum3;
  assign srem[0]  = '0;
  assign sroot[0] = '0;

  for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
    crcg_sqrt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .ctl_in   (sctl[g]),
      .rad_in   (srad[g]),
      .rem_in   (srem[g]),
      .root_in  (sroot[g]),
      .ctl_out  (sctl[g+1]),
      .rad_out  (srad[g+1]),
      .rem_out  (srem[g+1]),
      .root_out (sroot[g+1])
    );
  end

  // Contact decision.
  logic [ROOT_W-1:0] span;
  logic              stretched;
  logic              emit;
  div_ctl_t          dctl [0:Q_W];
  logic [2:0][DREM_W-1:0] drem [0:Q_W];
  logic [2:0][Q_W-1:0]    dq   [0:Q_W];

  always_comb begin
    span      = sroot[ROOT_W];
    stretched = span >= rest_length;
    emit      = (link_kind == LINK_ROD) ? (span != rest_length) : stretched;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dctl[0].valid <= 1'b0;
    end else if (adv) begin
      dctl[0].valid <= sctl[ROOT_W].valid && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dctl[0].flip  <= (link_kind == LINK_ROD) && !stretched;
      dctl[0].sign  <= sctl[ROOT_W].sign;
      dctl[0].span  <= span;
      dctl[0].depth <= stretched ? span - rest_length : rest_length - span;
      dctl[0].rest  <= (link_kind == LINK_ROD) ? '0 : restitution_coef;
      for (int i = 0; i < 3; i++) begin
        drem[0][i] <= {{(DREM_W-MAG_W){1'b0}}, sctl[ROOT_W].mag[i]};
      end
    end
  end

  assign dq[0] = '0;

  // Divider chain: one quotient bit per cell, three lanes side by side.
  for (genvar g = 0; g < Q_W; g++) begin : g_div
    crcg_div_cell #(.Q_W(Q_W), .FIRST(g == 0)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (adv),
      .ctl_in  (dctl[g]),
      .rem_in  (drem[g]),
      .q_in    (dq[g]),
      .ctl_out (dctl[g+1]),
      .rem_out (drem[g+1]),
      .q_out   (dq[g+1])
    );
  end

  // Output register.
  logic [2:0][NORM_W-1:0] nrm;
  div_ctl_t               fin;

  always_comb begin
    fin = dctl[Q_W];
    for (int i = 0; i < 3; i++) begin
      if (fin.span == '0) begin
        nrm[i] = '0;
      end else if (fin.sign[i] ^ fin.flip) begin
        nrm[i] = -{{(NORM_W-Q_W){1'b0}}, dq[Q_W][i]};
      end else begin
        nrm[i] = {{(NORM_W-Q_W){1'b0}}, dq[Q_W][i]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      contact.valid <= 1'b0;
    end else if (adv) begin
      contact.valid <= fin.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      contact.normal_x            <= nrm[0];
      contact.normal_y            <= nrm[1];
      contact.normal_z            <= nrm[2];
      contact.depth               <= fin.depth;
      contact.contact_restitution <= fin.rest;
    end
  end

endmodule
`default_nettype wire

@@ hdl/crcg_checker.sv @@
`default_nettype none
`include "cable_rod_contact_generator_defines.svh"
module crcg_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [32:0] out_depth,
  input wire logic [16:0] out_rest
);

  // A held contact keeps its valid and payload.
  `CRCG_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `CRCG_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready,
                    $stable(out_depth) && $stable(out_rest))
  // Restitution never exceeds one.
  `CRCG_ASSERT_ALWAYS(a_rest_range, clk, rst, !out_valid || out_rest <= 17'd65536)
  // An empty output stage never blocks the input.
  `CRCG_ASSERT_ALWAYS(a_in_ready, clk, rst, out_valid || in_ready)
  // No contact right after reset.
  `CRCG_ASSERT_SAME(a_reset_clear, clk, $past(rst), !out_valid)

endmodule

bind cable_rod_contact_generator crcg_checker u_crcg_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pos.valid),
  .in_ready  (pos.ready),
  .out_valid (contact.valid),
  .out_ready (contact.ready),
  .out_depth (contact.depth),
  .out_rest  (contact.contact_restitution)
);
`default_nettype wire

@@ dv/cable_rod_contact_generator_tb.sv @@
`default_nettype none
module cable_rod_contact_generator_tb;
  import crcg_pkg::*;

  localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 80;
  localparam logic [DEPTH_W-1:0] LEN_MAX = 33'h1_FFFF_FFFF;

  typedef struct packed {
    logic signed [31:0] fx, fy, fz, sx, sy, sz;
  } link_t;

  typedef struct packed {
    logic signed [17:0] nx, ny, nz;
    logic [32:0]        depth;
    logic [16:0]        rest;
  } contact_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  crcg_pos_if     pos_ch();
  crcg_contact_if contact_ch();
  crcg_cfg_if     cfg_ch();

  cable_rod_contact_generator DUT (
    .clk(clk), .rst(rst), .pos(pos_ch), .contact(contact_ch), .cfg(cfg_ch)
  );

  always #6 clk = ~clk;

  // mirror of the block's registers
  logic        mir_kind = 1'b0;
  logic [32:0] mir_rest_len = REST_INIT;
  logic [16:0] mir_restc = '0;

  link_t    pending_links[$];
  contact_t expected_contacts[$];
  int       mismatches = 0;
  int       hold_off = 0;
  int       src_gap = 0;
  int       snk_gap = 0;
  bit       took = 1'b0;

  function automatic bit predict_contact(link_t p, output contact_t c);
    logic signed [32:0] d[3];
    logic [32:0] m[3];
    logic [65:0] sum;
    logic [32:0] span, cand, dep;
    logic [48:0] q;
    bit flip, neg;
    d[0] = $signed({p.sx[31], p.sx}) - $signed({p.fx[31], p.fx});
    d[1] = $signed({p.sy[31], p.sy}) - $signed({p.fy[31], p.fy});
    d[2] = $signed({p.sz[31], p.sz}) - $signed({p.fz[31], p.fz});
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      m[i] = d[i][32] ? -d[i] : d[i];
      sum += {33'b0, m[i]} * {33'b0, m[i]};
    end
    span = '0;
    for (int b = 32; b >= 0; b--) begin
      cand = span | (33'd1 << b);
      if ({33'b0, cand} * {33'b0, cand} <= sum) span = cand;
    end
    flip = 1'b0;
    c = '0;
    if (mir_kind != LINK_ROD) begin
      if (span < mir_rest_len) return 1'b0;
      dep = span - mir_rest_len;
      c.rest = mir_restc;
    end else begin
      if (span == mir_rest_len) return 1'b0;
      if (span > mir_rest_len) dep = span - mir_rest_len;
      else begin
        dep = mir_rest_len - span;
        flip = 1'b1;
      end
    end
    c.depth = dep;
    for (int i = 0; i < 3; i++) begin
      q = (span == 0) ? '0 : ({16'b0, m[i]} << 16) / {16'b0, span};
      neg = d[i][32] != flip;
      if (i == 0) c.nx = neg ? -q[17:0] : q[17:0];
      if (i == 1) c.ny = neg ? -q[17:0] : q[17:0];
      if (i == 2) c.nz = neg ? -q[17:0] : q[17:0];
    end
    return 1'b1;
  endfunction

  initial begin
    pos_ch.valid = 1'b0;
    {pos_ch.first_x, pos_ch.first_y, pos_ch.first_z} = '0;
    {pos_ch.second_x, pos_ch.second_y, pos_ch.second_z} = '0;
    contact_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_LINK_KIND;
    cfg_ch.data = '0;
  end

  // record input transfers and predict
  always @(posedge clk) begin
    contact_t c;
    took <= !rst && pos_ch.valid && pos_ch.ready;
    if (!rst && pos_ch.valid && pos_ch.ready) begin
      if (predict_contact({pos_ch.first_x, pos_ch.first_y, pos_ch.first_z,
                           pos_ch.second_x, pos_ch.second_y, pos_ch.second_z}, c))
        expected_contacts.push_back(c);
    end
  end

  // driver
  always @(negedge clk) begin
    link_t l;
    logic nxt_valid;
    nxt_valid = pos_ch.valid;
    if (!rst && (took || !pos_ch.valid)) begin
      nxt_valid = 1'b0;
      if (src_gap > 0) src_gap <= src_gap - 1;
      else if (pending_links.size() > 0) begin
        l = pending_links.pop_front();
        {pos_ch.first_x, pos_ch.first_y, pos_ch.first_z,
         pos_ch.second_x, pos_ch.second_y, pos_ch.second_z} <= l;
        nxt_valid = 1'b1;
        src_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      end
    end
    pos_ch.valid <= nxt_valid;
  end

  always @(negedge clk)
    if (hold_off > 0) hold_off <= hold_off - 1;

  // receiver stalls
  always @(negedge clk) begin
    if (rst) contact_ch.ready <= 1'b0;
    else if (contact_ch.valid && contact_ch.ready) begin
      snk_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      contact_ch.ready <= 1'b0;
    end else if (snk_gap > 0) begin
      snk_gap <= snk_gap - 1;
      contact_ch.ready <= 1'b0;
    end else contact_ch.ready <= (hold_off == 0);
  end

  // monitor
  always @(posedge clk) begin
    contact_t e, a;
    if (!rst && contact_ch.valid && contact_ch.ready) begin
      a = {contact_ch.normal_x, contact_ch.normal_y, contact_ch.normal_z,
           contact_ch.depth, contact_ch.contact_restitution};
      if (expected_contacts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected contact %h", a);
      end else begin
        e = expected_contacts.pop_front();
        if (e !== a) begin
          mismatches++;
          if (mismatches <= 10)
            $display("contact mismatch: exp n=(%0d,%0d,%0d) d=%0d r=%0d got n=(%0d,%0d,%0d) d=%0d r=%0d",
                     e.nx, e.ny, e.nz, e.depth, e.rest,
                     a.nx, a.ny, a.nz, a.depth, a.rest);
        end
      end
    end
  end

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [32:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_LINK_KIND:   mir_kind = val[0];
      REG_REST_LENGTH: mir_rest_len = val;
      REG_RESTITUTION: mir_restc = (val[16:0] > REST_ONE) ? REST_ONE : val[16:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    wait (pending_links.size() == 0 && !pos_ch.valid && expected_contacts.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic link_t rand_link(logic [32:0] near);
    link_t l;
    int sel;
    l = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    sel = $urandom_range(0, 9);
    if (sel < 7) begin
      // second near first, distance around near (the rest length, or 100000 above 2000000)
      l.sx = l.fx + $signed(near[31:0]) + $signed($urandom_range(0, 400000)) - 200000;
      l.sy = l.fy + $signed($urandom_range(0, 200000)) - 100000;
      l.sz = l.fz + $signed($urandom_range(0, 200000)) - 100000;
      if ($urandom_range(0, 1)) {l.fx, l.sx} = {l.sx, l.fx};
    end else if (sel == 7) begin
      {l.sx, l.sy, l.sz} = {l.fx, l.fy, l.fz};
    end
    return l;
  endfunction

  task automatic run_phase(logic kind, logic [32:0] len, logic [32:0] restc, int n, int hold);
    write_reg(REG_LINK_KIND, {32'h1_2345_678, kind});
    write_reg(REG_REST_LENGTH, len);
    write_reg(REG_RESTITUTION, restc);
    hold_off = hold;
    for (int i = 0; i < n; i++)
      pending_links.push_back(rand_link((len > 33'd2000000) ? 33'd100000 : len));
    drain();
  endtask

  localparam logic signed [31:0] PMAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] PMIN = 32'sh8000_0000;

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    // directed, register defaults: cable of length one
    pending_links.push_back({6{32'sd0}});
    pending_links.push_back({32'sd0, 32'sd0, 32'sd0, 32'sd65536, 32'sd0, 32'sd0});
    pending_links.push_back({32'sd0, 32'sd0, 32'sd0, 32'sd0, -32'sd65536, 32'sd0});
    pending_links.push_back({32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd65535});
    pending_links.push_back({PMIN, PMIN, PMIN, PMAX, PMAX, PMAX});
    pending_links.push_back({PMAX, PMAX, PMAX, PMIN, PMIN, PMIN});
    pending_links.push_back({PMAX, PMIN, PMAX, PMIN, PMAX, PMIN});
    pending_links.push_back({PMIN, 32'sd0, 32'sd0, PMAX, 32'sd0, 32'sd0});
    pending_links.push_back({32'sd3, 32'sd4, 32'sd0, -32'sd3, -32'sd4, 32'sd0});
    drain();
    write_reg(REG_UNUSED, LEN_MAX);
    write_reg(REG_REST_LENGTH, '0);
    pending_links.push_back({6{32'sd0}});
    pending_links.push_back({PMIN, PMIN, PMIN, PMAX, PMAX, PMAX});
    drain();
    write_reg(REG_LINK_KIND, {32'b0, LINK_ROD});
    write_reg(REG_REST_LENGTH, 33'd65536);
    pending_links.push_back({6{32'sd0}});
    pending_links.push_back({32'sd0, 32'sd0, 32'sd0, 32'sd65536, 32'sd0, 32'sd0});
    pending_links.push_back({32'sd0, 32'sd0, 32'sd0, 32'sd1000, -32'sd2000, 32'sd3000});
    pending_links.push_back({32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, -32'sd200000});
    pending_links.push_back({PMAX, PMAX, PMAX, PMIN, PMIN, PMIN});
    drain();
    // random phases
    run_phase(1'b0, 33'd65536, 33'd32768, 150, 400);
    run_phase(1'b0, 33'd0, 33'h1_FFFF, 120, 0);
    run_phase(1'b1, 33'd100000, 33'd65536, 170, 0);
    run_phase(1'b0, 33'd150000, 33'd70000, 130, 0);
    run_phase(1'b1, 33'd0, 33'd12345, 80, 0);
    run_phase(1'b1, LEN_MAX, 33'd0, 80, 0);
    run_phase(1'b0, LEN_MAX, 33'd65535, 60, 0);
    run_phase(1'b1, 33'd80000, 33'd1, 60, 0);
    if (mismatches == 0 && expected_contacts.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #(12 * 500000);
    $display("Simulation FAILED");
    $finish;
  end
endmodule
`default_nettype wire
